[hw/rtl/trust_gate_with_hysteresis_assert.svh]
// Assertion macros for the trust gate checker.
`ifndef TRUST_GATE_WITH_HYSTERESIS_ASSERT_SVH
`define TRUST_GATE_WITH_HYSTERESIS_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define TGH_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("trust gate assertion failed");

// Check that a condition at one edge implies another at the next edge.
`define TGH_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("trust gate assertion failed");

`endif

[hw/rtl/tgh_pkg.sv]
`default_nettype none

package tgh_pkg;

  localparam int unsigned WINDOW  = 32;
  localparam int unsigned FRAC_W  = 17;
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned RATE_W  = 21;
  localparam int unsigned CFG_W   = 21;
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [FRAC_W-1:0] Q16_ONE = 17'd65536;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIGHT_OFF    = 3'd0,
    CFG_SIGHT_ON     = 3'd1,
    CFG_RESID_MAX    = 3'd2,
    CFG_RESID_RECOV  = 3'd3,
    CFG_REV_FADE     = 3'd4,
    CFG_DIR_FLIP     = 3'd5,
    CFG_REARM        = 3'd6,
    CFG_FADE_RATE    = 3'd7
  } cfg_idx_e;

endpackage

`default_nettype wire

[hw/rtl/trust_gate_with_hysteresis.sv]
// An accepted word is held in the input register, then written to the result register.
// Throughput: one word per cycle; the input stalls only while a result waits on out_stall_i.
// The fade step divides rate*dt by 10^6 with a reciprocal multiply behind the input register.
// Reset (rst_ni low, asynchronous): flags, accumulators, window, fade, share and
// configuration return to their defaults; no word is pending.
`default_nettype none

module trust_gate_with_hysteresis
  import tgh_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,

  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [CFG_W-1:0]         cfg_data_i,

  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     command_i,
  input  wire logic                     sample_valid_i,
  input  wire logic                     stale_i,
  input  wire logic                     fit_valid_i,
  input  wire logic [DIST_W-1:0]        fit_residual_i,
  input  wire logic signed [DIST_W-1:0] dist_delta_i,
  input  wire logic [15:0]              dt_us_i,

  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          trusted_o,
  output logic                          link_good_o,
  output logic                          sight_good_o,
  output logic                          fit_good_o,
  output logic                          policy_good_o,
  output logic                          heading_forward_o,
  output logic [FRAC_W-1:0]             fade_level_o,
  output logic [FRAC_W-1:0]             valid_share_o
);

  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned REC_K = 16 + 2 * CNT_W;
  localparam int unsigned REC_W = REC_K + 1;

  localparam int unsigned PROD_W    = RATE_W + 16;
  localparam int unsigned FADE_PRE  = 6;
  localparam int unsigned FADE_PW   = PROD_W - FADE_PRE;
  localparam int unsigned FADE_K    = 45;
  localparam logic [31:0] FADE_REC  = 32'(((64'd1 << FADE_K) + 64'd15624) / 64'd15625);
  localparam int unsigned STEP_W    = 18;

  typedef struct packed {
    logic                      cmd;
    logic                      sample_valid;
    logic                      stale;
    logic                      fit_lose;
    logic                      fit_gain;
    logic signed [DIST_W-1:0]  delta;
    logic [FADE_PW-1:0]        fade_prod;
  } in_word_t;

  // configuration
  logic [FRAC_W-1:0] sight_off_q, sight_on_q, recov_q;
  logic [DIST_W-1:0] resid_max_q, rev_fade_q, dir_flip_q, rearm_q;
  logic [RATE_W-1:0] fade_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sight_off_q <= 17'd32768;
      sight_on_q  <= 17'd52429;
      resid_max_q <= 16'd100;
      recov_q     <= 17'd52429;
      rev_fade_q  <= 16'd500;
      dir_flip_q  <= 16'd300;
      rearm_q     <= 16'd1000;
      fade_rate_q <= 21'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SIGHT_OFF:   sight_off_q <= cfg_data_i[FRAC_W-1:0];
        CFG_SIGHT_ON:    sight_on_q  <= cfg_data_i[FRAC_W-1:0];
        CFG_RESID_MAX:   resid_max_q <= cfg_data_i[DIST_W-1:0];
        CFG_RESID_RECOV: recov_q     <= cfg_data_i[FRAC_W-1:0];
        CFG_REV_FADE:    rev_fade_q  <= cfg_data_i[DIST_W-1:0];
        CFG_DIR_FLIP:    dir_flip_q  <= cfg_data_i[DIST_W-1:0];
        CFG_REARM:       rearm_q     <= cfg_data_i[DIST_W-1:0];
        CFG_FADE_RATE:   fade_rate_q <= cfg_data_i[RATE_W-1:0];
        default:         fade_rate_q <= fade_rate_q;
      endcase
    end
  end

  // input register
  logic     in_valid_q;
  in_word_t in_q, in_d;
  logic     accept, fire;
  logic [PROD_W-1:0] fade_prod_full;
  logic [32:0]       recov_lim;

  assign fire       = in_valid_q && !(out_valid_o && out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    fade_prod_full  = PROD_W'(fade_rate_q) * PROD_W'(dt_us_i);
    recov_lim       = 33'(resid_max_q) * 33'(recov_q);
    in_d.cmd          = command_i;
    in_d.sample_valid = sample_valid_i;
    in_d.stale        = stale_i;
    in_d.fit_lose     = !fit_valid_i || (fit_residual_i > resid_max_q);
    in_d.fit_gain     = {1'b0, fit_residual_i, 16'd0} <= recov_lim;
    in_d.delta        = dist_delta_i;
    in_d.fade_prod    = fade_prod_full[PROD_W-1:FADE_PRE];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_d;
    end
  end

  // reciprocal table for the share
  logic [REC_W-1:0] recip_tab [2**CNT_W];

  for (genvar gi = 0; gi < 2**CNT_W; gi++) begin : g_recip
    if (gi == 0) begin : g_zero
      assign recip_tab[gi] = '0;
    end else begin : g_val
      localparam logic [REC_W-1:0] RV =
        REC_W'(((64'd1 << REC_K) + 64'(gi) - 64'd1) / 64'(gi));
      assign recip_tab[gi] = RV;
    end
  end

  // tracker state
  logic [WINDOW-1:0] window_q, window_d;
  logic [CNT_W-1:0]  count_q, count_d, ones_q, ones_d;
  logic              link_q, link_d, sight_q, sight_d, fit_q, fit_d;
  logic              policy_q, policy_d, fwd_flag_q, fwd_flag_d;
  logic [FRAC_W-1:0] rev_q, rev_d, fade_q, fade_d, share_q, share_d;
  logic [DIST_W-1:0] fwd_q, fwd_d;

  logic [CNT_W+REC_W-1:0] share_prod;
  logic [FRAC_W-1:0]      share_new;
  logic signed [18:0]     rev_sum;
  logic signed [17:0]     fwd_sum;
  logic [FRAC_W-1:0]      rev_max;
  logic [DIST_W-1:0]      flip;
  logic [63:0]            step_prod;
  logic [STEP_W-1:0]      step;
  logic [FRAC_W-1:0]      gap;
  logic                   trust;

  always_comb begin
    window_d   = window_q;
    count_d    = count_q;
    ones_d     = ones_q;
    link_d     = link_q;
    sight_d    = sight_q;
    fit_d      = fit_q;
    policy_d   = policy_q;
    fwd_flag_d = fwd_flag_q;
    rev_d      = rev_q;
    fwd_d      = fwd_q;
    fade_d     = fade_q;
    share_d    = share_q;

    share_prod = CNT_W'(ones_q) * recip_tab[count_q];
    share_new  = share_prod[REC_K-16 +: FRAC_W];
    rev_max    = FRAC_W'(rev_fade_q) + FRAC_W'(dir_flip_q);
    rev_sum    = $signed({2'b00, rev_q}) - 19'(in_q.delta);
    fwd_sum    = $signed({2'b00, fwd_q}) + 18'(in_q.delta);
    flip       = (dir_flip_q < rev_fade_q) ? dir_flip_q : rev_fade_q;
    step_prod  = 64'(in_q.fade_prod) * 64'(FADE_REC);
    step       = step_prod[FADE_K +: STEP_W];
    trust      = 1'b0;
    gap        = '0;

    if (in_q.cmd == CMD_SAMPLE) begin
      window_d = {window_q[WINDOW-2:0], in_q.sample_valid};
      if (count_q != CNT_W'(WINDOW)) begin
        count_d = count_q + 1'b1;
      end
      if (in_q.sample_valid && !window_q[WINDOW-1]) begin
        ones_d = ones_q + 1'b1;
      end else if (!in_q.sample_valid && window_q[WINDOW-1]) begin
        ones_d = ones_q - 1'b1;
      end
    end else begin
      link_d  = !in_q.stale;
      share_d = share_new;

      if (share_new <= sight_off_q) begin
        sight_d = 1'b0;
      end else if (share_new >= sight_on_q && count_q >= CNT_W'(WINDOW / 2)) begin
        sight_d = 1'b1;
      end

      if (in_q.fit_lose) begin
        fit_d = 1'b0;
      end else if (in_q.fit_gain) begin
        fit_d = 1'b1;
      end

      if (rev_sum < 0) begin
        rev_d = '0;
      end else if (rev_sum > $signed({2'b00, rev_max})) begin
        rev_d = rev_max;
      end else begin
        rev_d = rev_sum[FRAC_W-1:0];
      end

      if (fwd_sum < 0) begin
        fwd_d = '0;
      end else if (fwd_sum > $signed({2'b00, rearm_q})) begin
        fwd_d = rearm_q;
      end else begin
        fwd_d = fwd_sum[DIST_W-1:0];
      end

      if (fwd_d >= rearm_q) begin
        fwd_flag_d = 1'b1;
      end else if (rev_d > FRAC_W'(flip)) begin
        fwd_flag_d = 1'b0;
      end

      if (rev_d > FRAC_W'(rev_fade_q)) begin
        policy_d = 1'b0;
      end else if (rev_d == '0) begin
        policy_d = 1'b1;
      end

      trust = link_d && sight_d && fit_d && policy_d;
      if (trust) begin
        gap = Q16_ONE - fade_q;
        fade_d = (step >= STEP_W'(gap)) ? Q16_ONE : fade_q + FRAC_W'(step);
      end else begin
        fade_d = (step >= STEP_W'(fade_q)) ? '0 : fade_q - FRAC_W'(step);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= '0;
      count_q    <= '0;
      ones_q     <= '0;
      link_q     <= 1'b0;
      sight_q    <= 1'b0;
      fit_q      <= 1'b0;
      policy_q   <= 1'b1;
      fwd_flag_q <= 1'b1;
      rev_q      <= '0;
      fwd_q      <= '0;
      fade_q     <= '0;
      share_q    <= '0;
    end else if (fire) begin
      window_q   <= window_d;
      count_q    <= count_d;
      ones_q     <= ones_d;
      link_q     <= link_d;
      sight_q    <= sight_d;
      fit_q      <= fit_d;
      policy_q   <= policy_d;
      fwd_flag_q <= fwd_flag_d;
      rev_q      <= rev_d;
      fwd_q      <= fwd_d;
      fade_q     <= fade_d;
      share_q    <= share_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (fire) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      trusted_o         <= link_d && sight_d && fit_d && policy_d;
      link_good_o       <= link_d;
      sight_good_o      <= sight_d;
      fit_good_o        <= fit_d;
      policy_good_o     <= policy_d;
      heading_forward_o <= fwd_flag_d;
      fade_level_o      <= fade_d;
      valid_share_o     <= share_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tgh_checker.sv]
`default_nettype none

`include "trust_gate_with_hysteresis_assert.svh"

module tgh_checker
  import tgh_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic              trusted_o,
  input wire logic              link_good_o,
  input wire logic              sight_good_o,
  input wire logic              fit_good_o,
  input wire logic              policy_good_o,
  input wire logic [FRAC_W-1:0] fade_level_o,
  input wire logic [FRAC_W-1:0] valid_share_o
);

  logic all_good;

  assign all_good = link_good_o && sight_good_o && fit_good_o && policy_good_o;

  `TGH_ASSERT(a_trusted_and, !out_valid_o || (trusted_o == all_good))
  `TGH_ASSERT(a_fade_range, !out_valid_o || (fade_level_o <= Q16_ONE))
  `TGH_ASSERT(a_share_range, !out_valid_o || (valid_share_o <= Q16_ONE))
  `TGH_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(fade_level_o))

endmodule

bind trust_gate_with_hysteresis tgh_checker u_tgh_checker (.*);

`default_nettype wire
